// File: rtl/core/vrrt_pkg.sv
// Shared types, codes and constants for the rectangle reservation table.
package vrrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int CFG_DATA_W          = 26;
    localparam int CFG_INDEX_W         = 3;
    localparam int COUNT_W             = 9;
    localparam int BOUND_W             = 44;

    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_Z   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRY  = 3'd3;

    localparam logic [7:0] OP_REMOVE = 8'd0;
    localparam logic [7:0] OP_PLACE  = 8'd1;

    typedef enum logic [2:0] {
        RSN_OK      = 3'd0,
        RSN_BADKEY  = 3'd1,
        RSN_MISSING = 3'd2,
        RSN_STALE   = 3'd3,
        RSN_INVALID = 3'd4,
        RSN_FULL    = 3'd5,
        RSN_OVERLAP = 3'd6
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [63:0]        entry_key;
        logic [7:0]         op_flag;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_z;
        logic [15:0]        extent_x;
        logic [15:0]        extent_z;
        logic [63:0]        update_slot;
        logic [63:0]        content_revision;
        logic               content_is_blank;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [2:0]         reject_reason;
        logic [63:0]        table_revision;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_z;
        logic [15:0]        extent_x;
        logic [15:0]        extent_z;
        logic [63:0]        update_slot;
        logic [63:0]        content_revision;
    } entry_t;

    // Write-side controls from the sequencer to the table store
    typedef struct packed {
        logic wr_en;
        logic live_set;
        logic live_clr;
    } store_cmd_t;

    typedef struct packed {
        logic signed [BOUND_W-1:0] min_x;
        logic signed [BOUND_W-1:0] max_x;
        logic signed [BOUND_W-1:0] min_z;
        logic signed [BOUND_W-1:0] max_z;
    } bounds_t;

    // Version order: update slot first, content revision when both slots are zero
    function automatic logic is_newer(input logic [63:0] nu, input logic [63:0] nr,
                                      input logic [63:0] pu, input logic [63:0] pr);
        logic res;
        if (nu != 64'd0 || pu != 64'd0)
            res = nu > pu;
        else
            res = nr > pr;
        return res;
    endfunction

endpackage

// File: rtl/core/vrrt_store.sv
// Entry memory with one registered read port and per-slot live flags.
module vrrt_store #(
    parameter int TABLE_DEPTH = vrrt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output vrrt_pkg::entry_t    rd_data,
    output logic                rd_live,
    output logic                rd_valid,
    output logic [AW-1:0]       rd_idx,
    input  vrrt_pkg::store_cmd_t cmd,
    input  logic [AW-1:0]       wr_addr,
    input  vrrt_pkg::entry_t    wr_data
);
    import vrrt_pkg::*;

    entry_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] live_reg;
    logic                   rd_valid_reg;
    logic [AW-1:0]          rd_idx_reg;
    entry_t                 rd_data_reg;

    // Write entry data
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read entry data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Track read strobe and index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (rd_en)
                rd_idx_reg <= rd_addr;
        end
    end

    // Set and clear live flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= '0;
        else if (cmd.live_set)
            live_reg[wr_addr] <= 1'b1;
        else if (cmd.live_clr)
            live_reg[wr_addr] <= 1'b0;
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_idx   = rd_idx_reg;
    assign rd_live  = live_reg[rd_idx_reg];

endmodule

// File: rtl/core/vrrt_bounds.sv
// Two-stage pipeline deriving region bounds in block coordinates.
module vrrt_bounds (
    input  logic                clk,
    input  logic signed [25:0]  span_x,
    input  logic signed [25:0]  span_z,
    input  logic [8:0]          chunk_size,
    output vrrt_pkg::bounds_t   bounds
);
    import vrrt_pkg::*;

    logic signed [33:0]      lo_x_reg, hi_x_reg, lo_z_reg, hi_z_reg;
    logic signed [33:0]      lo_x_next, lo_z_next;
    logic signed [BOUND_W-1:0] cs_ext;
    bounds_t                 bounds_reg;
    bounds_t                 bounds_next;

    // Chunk index range of the region
    always_comb
    begin
        lo_x_next = 34'(span_x) * 34'sd100;
        lo_z_next = 34'(span_z) * 34'sd100;
    end

    always_ff @(posedge clk)
    begin
        lo_x_reg <= lo_x_next;
        hi_x_reg <= lo_x_next + 34'sd100;
        lo_z_reg <= lo_z_next;
        hi_z_reg <= lo_z_next + 34'sd100;
    end

    // Scale to blocks
    always_comb
    begin
        cs_ext            = BOUND_W'($signed({1'b0, chunk_size}));
        bounds_next.min_x = BOUND_W'(lo_x_reg) * cs_ext;
        bounds_next.max_x = BOUND_W'(hi_x_reg) * cs_ext - 44'sd1;
        bounds_next.min_z = BOUND_W'(lo_z_reg) * cs_ext;
        bounds_next.max_z = BOUND_W'(hi_z_reg) * cs_ext - 44'sd1;
    end

    always_ff @(posedge clk)
    begin
        bounds_reg <= bounds_next;
    end

    assign bounds = bounds_reg;

endmodule

// File: rtl/core/versioned_rectangle_reservation_table.sv
// Top level: sequencer scanning the table once per request and deciding the change.
//
//  channel | signals                               | handshake
//  --------+---------------------------------------+-----------------------------
//  request | start, busy, req (req_t)              | taken when start && !busy
//  result  | done, rsp (rsp_t)                     | one-cycle strobe, no stall
//  config  | cfg_write, cfg_index, cfg_data        | written when cfg_write high
//
//  The scan reads one entry per cycle through the single memory read port, then the
//  sequencer passes through a drain state and a decide state; the result strobe is
//  registered from the decide state. The next request can be taken in the strobe
//  cycle at the earliest, so no new request is taken while one is in flight.
//  Reset clears the live flags, the table revision and the entry count at once.
//  The result strobe lasts one cycle and cannot be held off; busy is low during it.
module versioned_rectangle_reservation_table #(
    parameter int TABLE_DEPTH = vrrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  vrrt_pkg::req_t                   req,
    output logic                             done,
    output vrrt_pkg::rsp_t                   rsp,
    input  logic                             cfg_write,
    input  logic [vrrt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vrrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vrrt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST_ADDR = CW'(TABLE_DEPTH - 1);

    state_t state_reg, state_next;

    logic signed [25:0] span_x_reg, span_z_reg;
    logic [8:0]         chunk_size_reg, max_entry_reg;

    req_t               req_reg;
    logic [CW-1:0]      addr_reg, addr_next;
    logic               found_reg, free_reg, overlap_reg;
    logic [AW-1:0]      found_idx_reg, free_idx_reg;
    logic [63:0]        found_upd_reg, found_rev_reg;
    logic [63:0]        revision_reg, revision_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg;
    rsp_t               rsp_reg, rsp_next;

    entry_t             rd_data;
    logic               rd_live, rd_valid, rd_en;
    logic [AW-1:0]      rd_idx;
    store_cmd_t         cmd;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;
    bounds_t            bounds;

    logic               key_hit, hit_overlap;
    logic signed [33:0] a_lo_x, a_hi_x, a_lo_z, a_hi_z;
    logic signed [33:0] b_lo_x, b_hi_x, b_lo_z, b_hi_z;
    logic               valid_rect, newer;
    reason_t            reason;

    vrrt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (addr_reg[AW-1:0]),
        .rd_data  (rd_data),
        .rd_live  (rd_live),
        .rd_valid (rd_valid),
        .rd_idx   (rd_idx),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    vrrt_bounds u_bounds (
        .clk        (clk),
        .span_x     (span_x_reg),
        .span_z     (span_z_reg),
        .chunk_size (chunk_size_reg),
        .bounds     (bounds)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_x_reg     <= '0;
            span_z_reg     <= '0;
            chunk_size_reg <= 9'd16;
            max_entry_reg  <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REGION_X:   span_x_reg     <= $signed(cfg_data);
                CFG_REGION_Z:   span_z_reg     <= $signed(cfg_data);
                CFG_CHUNK_SIZE: chunk_size_reg <= cfg_data[8:0];
                CFG_MAX_ENTRY:  max_entry_reg  <= cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SCAN;
            ST_SCAN:   if (addr_reg == LAST_ADDR) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        rd_en     = 1'b0;
        addr_next = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr_next = '0;
            end
            ST_SCAN:
            begin
                rd_en     = 1'b1;
                addr_next = addr_reg + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            req_reg <= req;
    end

    // Compare one stored entry against the request
    always_comb
    begin
        a_lo_x  = 34'(req_reg.corner_x);
        a_lo_z  = 34'(req_reg.corner_z);
        a_hi_x  = a_lo_x + 34'($signed({1'b0, req_reg.extent_x})) - 34'sd1;
        a_hi_z  = a_lo_z + 34'($signed({1'b0, req_reg.extent_z})) - 34'sd1;
        b_lo_x  = 34'(rd_data.corner_x);
        b_lo_z  = 34'(rd_data.corner_z);
        b_hi_x  = b_lo_x + 34'($signed({1'b0, rd_data.extent_x})) - 34'sd1;
        b_hi_z  = b_lo_z + 34'($signed({1'b0, rd_data.extent_z})) - 34'sd1;
        key_hit = rd_live && (rd_data.key == req_reg.entry_key);
        hit_overlap = rd_live && !key_hit
                      && b_lo_x <= a_hi_x && b_hi_x >= a_lo_x
                      && b_lo_z <= a_hi_z && b_hi_z >= a_lo_z;
    end

    // Accumulate scan results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            overlap_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE)
        begin
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            overlap_reg <= 1'b0;
        end
        else if (rd_valid)
        begin
            if (key_hit)
                found_reg <= 1'b1;
            if (!rd_live && !free_reg)
                free_reg <= 1'b1;
            if (hit_overlap)
                overlap_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid && key_hit)
        begin
            found_idx_reg <= rd_idx;
            found_upd_reg <= rd_data.update_slot;
            found_rev_reg <= rd_data.content_revision;
        end
        if (rd_valid && !rd_live && !free_reg)
            free_idx_reg <= rd_idx;
    end

    // Decide the change
    always_comb
    begin
        valid_rect = req_reg.extent_x >= 16'd2 && req_reg.extent_z >= 16'd2
                     && ((req_reg.content_revision == 64'd0) == req_reg.content_is_blank)
                     && a_hi_x <= 34'sd2147483647 && a_hi_z <= 34'sd2147483647
                     && BOUND_W'(a_lo_x) <= bounds.max_x && BOUND_W'(a_hi_x) >= bounds.min_x
                     && BOUND_W'(a_lo_z) <= bounds.max_z && BOUND_W'(a_hi_z) >= bounds.min_z;
        newer = is_newer(req_reg.update_slot, req_reg.content_revision,
                         found_upd_reg, found_rev_reg);
        if (req_reg.entry_key == 64'd0 || req_reg.op_flag > OP_PLACE)
            reason = RSN_BADKEY;
        else if (req_reg.op_flag == OP_REMOVE)
        begin
            if (!found_reg)
                reason = RSN_MISSING;
            else if (!newer)
                reason = RSN_STALE;
            else
                reason = RSN_OK;
        end
        else if (!valid_rect)
            reason = RSN_INVALID;
        else if (found_reg && !newer)
            reason = RSN_STALE;
        else if (!found_reg && (count_reg >= max_entry_reg || !free_reg))
            reason = RSN_FULL;
        else if (overlap_reg)
            reason = RSN_OVERLAP;
        else
            reason = RSN_OK;
    end

    // Drive table writes and counters
    always_comb
    begin
        cmd           = '0;
        wr_addr       = found_reg ? found_idx_reg : free_idx_reg;
        wr_data.key              = req_reg.entry_key;
        wr_data.corner_x         = req_reg.corner_x;
        wr_data.corner_z         = req_reg.corner_z;
        wr_data.extent_x         = req_reg.extent_x;
        wr_data.extent_z         = req_reg.extent_z;
        wr_data.update_slot      = req_reg.update_slot;
        wr_data.content_revision = req_reg.content_revision;
        revision_next = revision_reg;
        count_next    = count_reg;
        if (state_reg == ST_DECIDE && reason == RSN_OK)
        begin
            revision_next = (revision_reg == '1) ? 64'd1 : revision_reg + 64'd1;
            if (req_reg.op_flag == OP_REMOVE)
            begin
                cmd.live_clr = 1'b1;
                count_next   = count_reg - COUNT_W'(1);
            end
            else
            begin
                cmd.wr_en = 1'b1;
                if (!found_reg)
                begin
                    cmd.live_set = 1'b1;
                    count_next   = count_reg + COUNT_W'(1);
                end
            end
        end
        rsp_next.accepted       = (reason == RSN_OK);
        rsp_next.reject_reason  = reason;
        rsp_next.table_revision = revision_next;
        rsp_next.entry_count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revision_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            revision_reg <= revision_next;
            count_reg    <= count_next;
            done_reg     <= (state_reg == ST_DECIDE);
        end
    end

    // Hold the result for its strobe
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
            rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");
    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.accepted == (rsp.reject_reason == RSN_OK)))
        else $error("accept flag disagrees with reason");
    a_rev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.accepted) |-> (rsp.table_revision != 64'd0))
        else $error("table revision zero after accepted change");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DECIDE) |=> $stable(count_reg))
        else $error("entry count moved outside decide");
`endif

endmodule
